[design/kmcd_pkg.sv]
// ----------------------------------------------------------------------------
// kmcd_pkg
// Shared types, field widths and codes of the key matrix change detector.
// ----------------------------------------------------------------------------
package kmcd_pkg;

  // input and output field widths
  localparam int ROW_W       = 3;
  localparam int COL_IN_W    = 16;
  localparam int KIND_W      = 2;
  localparam int EVT_COL_W   = 4;
  localparam int KEY_W       = 7;
  localparam int NOTE_W      = 4;
  localparam int COUNT_W     = 8;

  // stream packing
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_FIELD_W = ROW_W + EVT_COL_W + KEY_W + NOTE_W + COUNT_W + 1;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  // configuration port
  localparam int ROW_CFG_W   = 4;
  localparam int COL_CFG_W   = 5;
  localparam int CFG_W       = 5;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'd1;

  localparam logic [ROW_CFG_W-1:0] ROW_COUNT_RESET    = 4'd4;
  localparam logic [COL_CFG_W-1:0] COLUMN_COUNT_RESET = 5'd7;

  // clamped counts: rows up to 16, columns up to 32
  localparam int ROWS_EFF_W  = 5;
  localparam int COLS_EFF_W  = 6;

  // row * columns stays below 256 for a 3-bit row and at most 32 columns
  localparam int BASE_W      = 8;

  // key id mod 12 by reciprocal: floor(k * 171 / 2048) == floor(k / 12) for k < 128
  localparam int NOTES_PER_OCTAVE = 12;
  localparam int NOTE_RECIP       = 171;
  localparam int NOTE_SHIFT       = 11;
  localparam int NOTE_PROD_W      = 15;

  typedef enum logic [KIND_W-1:0] {
    KIND_PRESS   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_SUMMARY = 2'd2
  } event_kind_t;

  typedef struct packed {
    logic [ROW_W-1:0]   row;
    logic               summary;
    logic [COUNT_W-1:0] total;
    logic [BASE_W-1:0]  base;
  } job_hdr_t;

  typedef struct packed {
    event_kind_t         kind;
    logic [ROW_W-1:0]    row;
    logic [EVT_COL_W-1:0] column;
    logic [KEY_W-1:0]    key_id;
    logic [NOTE_W-1:0]   note_index;
    logic [COUNT_W-1:0]  active_count;
    logic                multiple_active;
    logic                last_event;
  } event_t;

  function automatic logic [NOTE_W-1:0] note_of(input logic [KEY_W-1:0] key);
    logic [NOTE_PROD_W-1:0] prod;
    logic [KEY_W-1:0]       quot;
    logic [KEY_W-1:0]       qx;
    prod = NOTE_PROD_W'(key) * NOTE_PROD_W'(NOTE_RECIP);
    quot = KEY_W'(prod >> NOTE_SHIFT);
    qx   = KEY_W'(quot * KEY_W'(NOTES_PER_OCTAVE));
    return NOTE_W'(key - qx);
  endfunction

endpackage

[design/kmcd_lane.sv]
// ----------------------------------------------------------------------------
// kmcd_lane
// One column: masks the sampled and stored levels and flags press or release.
// ----------------------------------------------------------------------------
module kmcd_lane (
  input  logic in_use,
  input  logic cur_bit,
  input  logic prev_bit,
  output logic cur_kept,
  output logic rose,
  output logic fell
);

  logic prev_kept;

  assign cur_kept  = in_use & cur_bit;
  assign prev_kept = in_use & prev_bit;
  assign rose      = cur_kept & ~prev_kept;
  assign fell      = prev_kept & ~cur_kept;

endmodule

[design/kmcd_emitter.sv]
// ----------------------------------------------------------------------------
// kmcd_emitter
// Merges one row's lane flags into an ordered event stream: presses in column
// order, then releases, then the scan summary; one event per cycle if ready.
// ----------------------------------------------------------------------------
module kmcd_emitter
  import kmcd_pkg::*;
#(
  parameter int MAX_COLUMNS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  logic [MAX_COLUMNS-1:0] load_rose,
  input  logic [MAX_COLUMNS-1:0] load_fell,
  input  job_hdr_t               load_hdr,
  output logic                   job_free,
  output logic                   out_valid,
  input  logic                   out_ready,
  output event_t                 out_evt
);

  localparam int CIDX_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

  logic                   job_valid;
  logic [MAX_COLUMNS-1:0] job_rose;
  logic [MAX_COLUMNS-1:0] job_fell;
  job_hdr_t               job_hdr;

  logic                   advance;
  logic                   step;
  logic                   use_rose;
  logic                   use_fell;
  logic                   is_summary;
  logic                   last;
  logic                   job_done;
  logic [MAX_COLUMNS-1:0] pick_vec;
  logic [MAX_COLUMNS-1:0] onehot;
  logic [MAX_COLUMNS-1:0] rose_rem;
  logic [MAX_COLUMNS-1:0] fell_rem;
  logic [CIDX_W-1:0]      col;
  logic [BASE_W-1:0]      key_full;
  logic [KEY_W-1:0]       key;
  event_t                 evt;

  assign advance    = !out_valid || out_ready;
  assign step       = job_valid && advance;
  assign use_rose   = |job_rose;
  assign use_fell   = !use_rose && (|job_fell);
  assign is_summary = !use_rose && !use_fell;
  assign pick_vec   = use_rose ? job_rose : job_fell;
  // isolate the lowest pending column
  assign onehot     = pick_vec & (~pick_vec + 1'b1);
  assign rose_rem   = use_rose ? (job_rose & ~onehot) : job_rose;
  assign fell_rem   = use_fell ? (job_fell & ~onehot) : job_fell;
  assign last       = is_summary || (rose_rem == '0 && fell_rem == '0 && !job_hdr.summary);
  assign job_done   = step && last;
  assign job_free   = !job_valid || job_done;

  always_comb begin
    col = '0;
    for (int i = 0; i < MAX_COLUMNS; i++) begin
      if (onehot[i]) begin
        col = CIDX_W'(i);
      end
    end
  end

  assign key_full = job_hdr.base + BASE_W'(col);
  assign key      = key_full[KEY_W-1:0];

  always_comb begin
    evt.row        = job_hdr.row;
    evt.last_event = last;
    if (is_summary) begin
      evt.kind            = KIND_SUMMARY;
      evt.column          = '0;
      evt.key_id          = '0;
      evt.note_index      = '0;
      evt.active_count    = job_hdr.total;
      evt.multiple_active = (job_hdr.total > COUNT_W'(1));
    end else begin
      evt.kind            = use_rose ? KIND_PRESS : KIND_RELEASE;
      evt.column          = EVT_COL_W'(col);
      evt.key_id          = key;
      evt.note_index      = note_of(key);
      evt.active_count    = '0;
      evt.multiple_active = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (load) begin
      job_valid <= 1'b1;
    end else if (job_done) begin
      job_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job_rose <= load_rose;
      job_fell <= load_fell;
      job_hdr  <= load_hdr;
    end else if (step) begin
      job_rose <= rose_rem;
      job_fell <= fell_rem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_evt <= evt;
    end
  end

  // a held job always has something left to send
  a_job_not_empty: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> (job_rose != '0 || job_fell != '0 || job_hdr.summary))
    else $error("emitter holds an empty job");

  // a new job never overwrites one that still has events
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load |-> (!job_valid || job_done))
    else $error("job loaded over a pending job");

  // finishing a job without a reload leaves the emitter idle
  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    job_done && !load |=> !job_valid)
    else $error("job still valid after its last event");

  // a summary is always the closing event of its row
  a_summary_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_evt.kind == KIND_SUMMARY |-> out_evt.last_event && out_evt.key_id == '0)
    else $error("summary event not closing its row");

endmodule

[design/key_matrix_change_detector.sv]
// ----------------------------------------------------------------------------
// key_matrix_change_detector
// Per-row change detection of a scanned key matrix with event stream output.
// ----------------------------------------------------------------------------
// Usage: each s_axis transfer carries the sampled column levels of one row.
// The row is compared with its levels from the previous scan in one column
// lane per column; the emitter then sends one m_axis transfer per changed key
// (presses in column order, then releases) and, on the last row in use, a
// scan summary with the number of active keys. tlast marks the final event
// of a row. A row with no change that is not the last row, or a row outside
// the rows in use, gives no events.
// Timing: a taken row waits in the emitter's job register, and each event
// passes through the output register to m_axis. The block sustains one
// event per cycle while the receiver is ready; the next row is taken in the
// cycle in which the previous row's last event enters the output register.
// Reset clears the stored row levels and the scan total, and sets the row
// and column counts to 4 and 7. When the receiver stalls, the output register
// holds its event and the emitter holds its job; s_axis_tready drops until
// the held job's last event is registered. Counts are written by the user
// through cfg_we/cfg_index/cfg_data while the block idles; not enforced.
// ----------------------------------------------------------------------------
module key_matrix_change_detector
  import kmcd_pkg::*;
#(
  parameter int MAX_ROWS    = 8,
  parameter int MAX_COLUMNS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // row_index [2:0], column_bits [18:3], zero [23:19]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // event_row [2:0], event_column [6:3], key_id [13:7], note_index [17:14],
  // active_count [25:18], multiple_active [26], zero [31:27]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // event_kind [1:0]
  output logic [KIND_W-1:0]      m_axis_tuser,
  output logic                   m_axis_tlast
);

  localparam int RIDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int PC_W   = $clog2(MAX_COLUMNS + 1);

  logic [ROW_CFG_W-1:0]   row_count;
  logic [COL_CFG_W-1:0]   column_count;
  logic [MAX_COLUMNS-1:0] prev_bits [MAX_ROWS];
  logic [COUNT_W-1:0]     scan_total;
  logic [COUNT_W-1:0]     scan_total_next;

  logic [ROWS_EFF_W-1:0]  rows_eff;
  logic [COLS_EFF_W-1:0]  cols_eff;
  logic [ROW_W-1:0]       row_index;
  logic [COL_IN_W-1:0]    column_bits;
  logic [RIDX_W-1:0]      row_sel;
  logic                   row_in_use;
  logic                   last_row;
  logic                   accept;
  logic                   make_job;
  logic [MAX_COLUMNS-1:0] prev_row;
  logic [MAX_COLUMNS-1:0] cur_vec;
  logic [MAX_COLUMNS-1:0] rose_vec;
  logic [MAX_COLUMNS-1:0] fell_vec;
  logic [PC_W-1:0]        pop;
  logic [COUNT_W:0]       sum;
  job_hdr_t               hdr;
  logic                   job_free;
  event_t                 evt;

  assign row_index   = s_axis_tdata[ROW_W-1:0];
  assign column_bits = s_axis_tdata[ROW_W +: COL_IN_W];
  assign row_sel     = RIDX_W'(row_index);

  // clamp the configured counts into range
  always_comb begin
    if (row_count == '0) begin
      rows_eff = ROWS_EFF_W'(1);
    end else if (ROWS_EFF_W'(row_count) > ROWS_EFF_W'(MAX_ROWS)) begin
      rows_eff = ROWS_EFF_W'(MAX_ROWS);
    end else begin
      rows_eff = ROWS_EFF_W'(row_count);
    end
    if (column_count == '0) begin
      cols_eff = COLS_EFF_W'(1);
    end else if (COLS_EFF_W'(column_count) > COLS_EFF_W'(MAX_COLUMNS)) begin
      cols_eff = COLS_EFF_W'(MAX_COLUMNS);
    end else begin
      cols_eff = COLS_EFF_W'(column_count);
    end
  end

  assign row_in_use = ROWS_EFF_W'(row_index) < rows_eff;
  assign last_row   = ROWS_EFF_W'(row_index) == (rows_eff - ROWS_EFF_W'(1));
  assign prev_row   = prev_bits[row_sel];

  for (genvar c = 0; c < MAX_COLUMNS; c++) begin : g_lane
    logic sample;
    if (c < COL_IN_W) begin : g_pin
      assign sample = column_bits[c];
    end else begin : g_nopin
      assign sample = 1'b0;
    end
    kmcd_lane u_lane (
      .in_use   (COLS_EFF_W'(c) < cols_eff),
      .cur_bit  (sample),
      .prev_bit (prev_row[c]),
      .cur_kept (cur_vec[c]),
      .rose     (rose_vec[c]),
      .fell     (fell_vec[c])
    );
  end

  always_comb begin
    pop = '0;
    for (int i = 0; i < MAX_COLUMNS; i++) begin
      pop = pop + PC_W'(cur_vec[i]);
    end
  end

  // row 0 restarts the scan total, later rows add with saturation
  always_comb begin
    sum = (row_index == '0) ? (COUNT_W + 1)'(pop)
                            : ({1'b0, scan_total} + (COUNT_W + 1)'(pop));
    scan_total_next = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
  end

  assign s_axis_tready = job_free;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign make_job      = accept && row_in_use && (rose_vec != '0 || fell_vec != '0 || last_row);

  always_comb begin
    hdr.row     = row_index;
    hdr.summary = last_row;
    hdr.total   = scan_total_next;
    hdr.base    = BASE_W'(BASE_W'(row_index) * BASE_W'(cols_eff));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= ROW_COUNT_RESET;
      column_count <= COLUMN_COUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW_COUNT:    row_count    <= cfg_data[ROW_CFG_W-1:0];
        REG_COLUMN_COUNT: column_count <= cfg_data[COL_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_total <= '0;
      for (int r = 0; r < MAX_ROWS; r++) begin
        prev_bits[r] <= '0;
      end
    end else if (accept && row_in_use) begin
      scan_total         <= scan_total_next;
      prev_bits[row_sel] <= cur_vec;
    end
  end

  kmcd_emitter #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_emitter (
    .clk       (clk),
    .rst       (rst),
    .load      (make_job),
    .load_rose (rose_vec),
    .load_fell (fell_vec),
    .load_hdr  (hdr),
    .job_free  (job_free),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_evt   (evt)
  );

  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, evt.multiple_active, evt.active_count,
                         evt.note_index, evt.key_id, evt.column, evt.row};
  assign m_axis_tuser = evt.kind;
  assign m_axis_tlast = evt.last_event;

endmodule

[tb/sv/kmcd_event_checker.sv]
// ----------------------------------------------------------------------------
// kmcd_event_checker
// Watches the configuration port and both streams of the key matrix change
// detector. It keeps its own copy of the stored row levels, the scan total and
// the counts, works out the key events that each accepted row causes, and
// compares every accepted output transfer field by field with the oldest one.
// ----------------------------------------------------------------------------
module kmcd_event_checker
  import kmcd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  // row_index [2:0], column_bits [18:3], zero [23:19]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // event_row [2:0], event_column [6:3], key_id [13:7], note_index [17:14],
  // active_count [25:18], multiple_active [26], zero [31:27]
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // event_kind [1:0]
  input  logic [KIND_W-1:0]      m_axis_tuser,
  input  logic                   m_axis_tlast,
  output int                     mismatch_count,
  output int                     events_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROWS_MAX = 8;
  localparam int COLS_MAX = 16;

  logic [ROW_CFG_W-1:0] row_count_q;
  logic [COL_CFG_W-1:0] column_count_q;
  logic [COL_IN_W-1:0]  row_levels [ROWS_MAX];
  logic [COUNT_W-1:0]   scan_total;
  event_t               key_events_due [$];
  int                   mismatches;
  event_t               got;
  event_t               want;
  logic [OUT_PAD_W-1:0] got_pad;

  function automatic string event_text(input event_t e);
    return $sformatf("kind %0d row %0d col %0d key %0d note %0d count %0d multi %0d last %0d",
                     e.kind, e.row, e.column, e.key_id, e.note_index, e.active_count,
                     e.multiple_active, e.last_event);
  endfunction

  // key events of one row transfer, presses before releases, summary on the last row
  function automatic void derive_key_events(input logic [ROW_W-1:0] row,
                                            input logic [COL_IN_W-1:0] levels);
    int rows, cols, total, n, made, pass, c, key;
    logic [COL_IN_W-1:0] mask, cur, prev, rose, fell, set;
    event_t ev;
    rows = (row_count_q == 0) ? 1 : (row_count_q > ROWS_MAX) ? ROWS_MAX : int'(row_count_q);
    cols = (column_count_q == 0) ? 1 :
           (column_count_q > COLS_MAX) ? COLS_MAX : int'(column_count_q);
    if (int'(row) >= rows) return;
    mask = COL_IN_W'((32'd1 << cols) - 1);
    cur  = levels & mask;
    prev = row_levels[row] & mask;
    rose = cur & ~prev;
    fell = prev & ~cur;
    n = $countones(rose) + $countones(fell) + ((int'(row) == rows - 1) ? 1 : 0);
    made = 0;
    for (pass = 0; pass < 2; pass++) begin
      set = (pass == 0) ? rose : fell;
      for (c = 0; c < cols; c++) begin
        if (set[c]) begin
          key = int'(row) * cols + c;
          ev = '0;
          if (pass == 0) ev.kind = KIND_PRESS;
          else ev.kind = KIND_RELEASE;
          ev.row        = row;
          ev.column     = EVT_COL_W'(c);
          ev.key_id     = KEY_W'(key);
          ev.note_index = NOTE_W'(key % NOTES_PER_OCTAVE);
          ev.last_event = (made == n - 1);
          key_events_due = {key_events_due, ev};
          made++;
        end
      end
    end
    row_levels[row] = cur;
    // total restarts on row 0 and saturates
    total = (row == 0) ? $countones(cur) : int'(scan_total) + $countones(cur);
    if (total > 255) total = 255;
    scan_total = COUNT_W'(total);
    if (int'(row) == rows - 1) begin
      ev = '0;
      ev.kind            = KIND_SUMMARY;
      ev.row             = row;
      ev.active_count    = scan_total;
      ev.multiple_active = (total > 1);
      ev.last_event      = 1'b1;
      key_events_due = {key_events_due, ev};
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      row_count_q    = ROW_COUNT_RESET;
      column_count_q = COLUMN_COUNT_RESET;
      foreach (row_levels[i]) row_levels[i] = '0;
      scan_total = '0;
      key_events_due.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_ROW_COUNT) row_count_q = cfg_data[ROW_CFG_W-1:0];
        else if (cfg_index == REG_COLUMN_COUNT) column_count_q = cfg_data[COL_CFG_W-1:0];
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind            = event_kind_t'(m_axis_tuser);
        got.row             = m_axis_tdata[2:0];
        got.column          = m_axis_tdata[6:3];
        got.key_id          = m_axis_tdata[13:7];
        got.note_index      = m_axis_tdata[17:14];
        got.active_count    = m_axis_tdata[25:18];
        got.multiple_active = m_axis_tdata[26];
        got.last_event      = m_axis_tlast;
        got_pad             = m_axis_tdata[OUT_TDATA_W-1:OUT_FIELD_W];
        if (key_events_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected event transfer: %s", event_text(got));
        end else begin
          want = key_events_due.pop_front();
          if (got.kind != want.kind || got.row != want.row || got.column != want.column ||
              got.key_id != want.key_id || got.note_index != want.note_index ||
              got.active_count != want.active_count ||
              got.multiple_active != want.multiple_active ||
              got.last_event != want.last_event || got_pad != '0) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("event mismatch at %0t", $realtime);
              $display("  expected %s", event_text(want));
              $display("  actual   %s pad %0h", event_text(got), got_pad);
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) derive_key_events(s_axis_tdata[2:0], s_axis_tdata[18:3]);
    end
    events_pending <= key_events_due.size();
    mismatch_count <= mismatches;
  end

endmodule

[tb/sv/key_matrix_change_detector_tb.sv]
// ----------------------------------------------------------------------------
// key_matrix_change_detector_tb
// Drives row transfers and count writes into the key matrix change detector,
// first a directed set of corner rows, then phases of random scans over
// several row and column counts with random gaps and output stalls. The
// event checker beside the block does the prediction and comparison.
// ----------------------------------------------------------------------------
module key_matrix_change_detector_tb
  import kmcd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROWS_MAX = 8;
  localparam int COLS_MAX = 16;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [KIND_W-1:0]      m_axis_tuser;
  logic                   m_axis_tlast;

  int                     mismatch_count;
  int                     events_pending;

  bit                     src_idles = 1'b0;
  bit                     sink_stalls = 1'b0;
  int                     stall_left = 0;
  int                     sink_roll;
  logic [ROW_CFG_W-1:0]   rows_set = ROW_COUNT_RESET;
  logic [COL_CFG_W-1:0]   cols_set = COLUMN_COUNT_RESET;
  logic [COL_IN_W-1:0]    sent_levels [ROWS_MAX];

  key_matrix_change_detector #(
    .MAX_ROWS    (ROWS_MAX),
    .MAX_COLUMNS (COLS_MAX)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  kmcd_event_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser),
    .m_axis_tlast   (m_axis_tlast),
    .mismatch_count (mismatch_count),
    .events_pending (events_pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #15_000_000;
    $display("key_matrix_change_detector: mismatch");
    $finish;
  end

  // receiver: mostly short stalls, a few long ones
  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!sink_stalls) begin
      m_axis_tready <= 1'b1;
    end else begin
      sink_roll = $urandom_range(0, 99);
      if (sink_roll < 70) begin
        m_axis_tready <= 1'b1;
      end else if (sink_roll < 95) begin
        m_axis_tready <= 1'b0;
        stall_left <= $urandom_range(0, 2);
      end else begin
        m_axis_tready <= 1'b0;
        stall_left <= $urandom_range(10, 40);
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_counts(input int rows, input int cols);
    write_reg(REG_ROW_COUNT, CFG_W'(rows));
    write_reg(REG_COLUMN_COUNT, CFG_W'(cols));
    rows_set = ROW_CFG_W'(rows);
    cols_set = COL_CFG_W'(cols);
  endtask

  // valid stays high across back-to-back transfers
  task automatic send_row(input logic [ROW_W-1:0] row, input logic [COL_IN_W-1:0] levels);
    int gap, roll;
    gap = 0;
    if (src_idles) begin
      roll = $urandom_range(0, 99);
      if (roll >= 90) gap = $urandom_range(8, 40);
      else if (roll >= 50) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'({levels, row});
    sent_levels[row] = levels;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // hold off until every event is out, then let any eventless row finish
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (events_pending != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic run_scans(input int n_items, input bit skip_first_row);
    int rows, cols, done, r, first, stop, roll;
    logic [COL_IN_W-1:0] v;
    rows = (rows_set == 0) ? 1 : (rows_set > ROWS_MAX) ? ROWS_MAX : int'(rows_set);
    cols = (cols_set == 0) ? 1 : (cols_set > COLS_MAX) ? COLS_MAX : int'(cols_set);
    done = 0;
    while (done < n_items) begin
      if ($urandom_range(0, 99) < 80) begin
        first = (skip_first_row && rows > 1) ? 1 : 0;
        // now and then a scan breaks off early
        stop = ($urandom_range(0, 9) == 0) ? $urandom_range(first, rows - 1) : rows - 1;
        for (r = first; r <= stop; r++) begin
          roll = $urandom_range(0, 99);
          v = sent_levels[r];
          if (roll < 25) v = sent_levels[r];
          else if (roll < 50) v = v ^ (COL_IN_W'(1) << $urandom_range(0, cols - 1));
          else if (roll < 75) v = COL_IN_W'($urandom);
          else if (roll < 88) v = '0;
          else v = '1;
          send_row(ROW_W'(r), v);
          done++;
        end
      end else begin
        r = $urandom_range(0, ROWS_MAX - 1);
        send_row(ROW_W'(r), COL_IN_W'($urandom));
        if (r < rows) done++;
      end
    end
  endtask

  initial begin
    int p;
    int rows_plan [9];
    int cols_plan [9];
    rows_plan = '{8, 1, 0, 15, 3, 8, 1, 0, 0};
    cols_plan = '{16, 1, 0, 31, 5, 1, 16, 0, 0};
    foreach (sent_levels[i]) sent_levels[i] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset counts: 4 rows, 7 columns
    send_row(3'd0, 16'h0000);  // no change on a row that is not the last
    send_row(3'd0, 16'hFFFF);  // columns above the count read as zero
    send_row(3'd1, 16'h0055);
    send_row(3'd2, 16'h0000);
    send_row(3'd3, 16'h007F);  // presses then summary
    send_row(3'd4, 16'h1234);  // rows outside the count are ignored
    send_row(3'd7, 16'hFFFF);
    send_row(3'd3, 16'h007F);  // summary alone
    send_row(3'd0, 16'h0000);  // every key released
    send_row(3'd0, 16'h0041);
    send_row(3'd0, 16'h0002);  // press and release in one row
    send_row(3'd3, 16'h0000);
    drain();

    set_counts(8, 16);
    send_row(3'd7, 16'hFFFF);  // largest burst
    send_row(3'd0, 16'hFFFF);
    send_row(3'd5, 16'hAAAA);
    send_row(3'd7, 16'h8000);
    send_row(3'd3, 16'h0000);  // no change on a row in use gives no events
    drain();

    for (p = 0; p < 9; p++) begin
      if (p >= 7) set_counts($urandom_range(0, 15), $urandom_range(0, 31));
      else set_counts(rows_plan[p], cols_plan[p]);
      src_idles = (p % 4 == 0) || (p % 4 == 2);
      sink_stalls <= (p % 4 == 0) || (p % 4 == 3);
      // total saturates when scans never restart at row 0
      run_scans(50, p == 3);
      drain();
    end

    if (mismatch_count == 0 && events_pending == 0) begin
      $display("key_matrix_change_detector: match");
    end else begin
      $display("key_matrix_change_detector: mismatch");
    end
    $finish;
  end

endmodule
